/* rtl/core/kpc_pkg.sv */
// shared constants, codes and helper functions of the kernel proximity classifier
package kpc_pkg;

    localparam int MAX_ROWS     = 256;
    localparam int MAX_FEATURES = 16;
    localparam int MAX_CLASSES  = 16;

    localparam int ROW_AW  = 8;                 // row address bits
    localparam int FEAT_AW = 4;                 // feature index bits
    localparam int ROW_CW  = ROW_AW + 1;        // row count holds MAX_ROWS itself
    localparam int FADDR_W = ROW_AW + FEAT_AW;

    localparam logic [ROW_CW-1:0] ROWS_FULL = ROW_CW'(MAX_ROWS);
    localparam logic [4:0]        FEAT_TOP  = 5'(MAX_FEATURES);

    // request kinds
    localparam logic [1:0] REQ_CLEAR = 2'd0;
    localparam logic [1:0] REQ_LOAD  = 2'd1;
    localparam logic [1:0] REQ_QUERY = 2'd2;

    // result status codes
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_NO_TRAIN = 2'd1;
    localparam logic [1:0] ST_FULL     = 2'd2;

    // fixed point constants
    localparam logic [31:0] Q30_E    = 32'd2918732889;
    localparam logic [31:0] Q30_EINV = 32'd395007542;
    localparam logic [30:0] Q30_ONE  = 31'd1073741824;
    localparam logic [31:0] K_Q24    = 32'd7308155;
    localparam logic [35:0] D_LIMIT  = 36'd458752;     // 7.0 with 16 fraction bits
    localparam logic [24:0] X_LIMIT  = 25'd16777216;   // 16.0 with 20 fraction bits

    // floor(2^32 / k) for the horner divisions, k from 2 to 10
    function automatic logic [31:0] recip(input logic [3:0] k);
        logic [31:0] r;
        case (k)
            4'd2:    r = 32'd2147483648;
            4'd3:    r = 32'd1431655765;
            4'd4:    r = 32'd1073741824;
            4'd5:    r = 32'd858993459;
            4'd6:    r = 32'd715827882;
            4'd7:    r = 32'd613566756;
            4'd8:    r = 32'd536870912;
            4'd9:    r = 32'd477218588;
            4'd10:   r = 32'd429496729;
            default: r = 32'd0;
        endcase
        return r;
    endfunction

    function automatic logic [3:0] clamp_label(input logic [3:0] l);
        logic [3:0] top;
        top = 4'(MAX_CLASSES - 1);
        return (l > top) ? top : l;
    endfunction

endpackage

/* rtl/core/kpc_ram.sv */
// generic single write port, single read port ram with registered read
module kpc_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

/* rtl/core/kpc_mul.sv */
// shared 32 x 32 multiplier with registered product
module kpc_mul (
    input  logic        aclk,
    input  logic [31:0] a,
    input  logic [31:0] b,
    output logic [63:0] prod
);

    logic [63:0] prod_reg;

    always_ff @(posedge aclk) begin
        prod_reg <= a * b;
    end

    assign prod = prod_reg;

endmodule

/* rtl/core/kernel_proximity_classifier.sv */
// top level of the kernel proximity classifier: request handling, sequencer and result port
// clear and load requests finish on acceptance; a full-store load or an empty-store query gives
// one result once the result register is free; a query row runs the kernel for every stored row,
// the exponent loop once per unit of n, the integer part of the kernel exponent (a row beyond the
// distance cutoff skips the kernel), then a label scan plus result stalls, not ready meanwhile
// aresetn (synchronous, active low) empties the store, sets feature_count to 1, drops results
module kernel_proximity_classifier (
    input  logic        aclk,
    input  logic        aresetn,
    // configuration: feature_count
    input  logic        cfg_we,
    input  logic [4:0]  cfg_wdata,
    // request channel
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // [15:0] feature_value, [19:16] sample_class, rest zero
    input  logic [1:0]  s_tuser,   // [1:0] req_type
    // result channel
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // [3:0] class_label, [35:4] score, rest zero
    output logic [1:0]  m_tuser,   // [1:0] status
    output logic        m_tlast
);
    import kpc_pkg::*;

    typedef enum logic [17:0] {
        S_IDLE = 18'h00001,
        S_EMIT = 18'h00002,
        S_RD   = 18'h00004,
        S_DIFF = 18'h00008,
        S_ACC  = 18'h00010,
        S_K0   = 18'h00020,
        S_K1   = 18'h00040,
        S_K2   = 18'h00080,
        S_K3   = 18'h00100,
        S_EXP  = 18'h00200,
        S_EXPW = 18'h00400,
        S_H0   = 18'h00800,
        S_H1   = 18'h01000,
        S_H2   = 18'h02000,
        S_FIN  = 18'h04000,
        S_TERM = 18'h08000,
        S_ADD  = 18'h10000,
        S_OUT  = 18'h20000
    } state_t;

    // control state
    state_t              state_reg, state_next;
    logic [4:0]          fcnt_reg, fcnt_next;
    logic [3:0]          elem_reg, elem_next;
    logic [ROW_CW-1:0]   rows_reg, rows_next;
    logic [15:0]         mask_reg, mask_next;
    logic                m_valid_reg, m_valid_next;

    // datapath state
    logic [ROW_CW-1:0]   row_reg, row_next;
    logic [3:0]          j_reg, j_next;
    logic [35:0]         d_reg, d_next;
    logic [5:0]          dhi_reg, dhi_next;
    logic [54:0]         xlo_reg, xlo_next;
    logic [31:0]         a_reg, a_next;
    logic [4:0]          cnt_reg, cnt_next;
    logic [29:0]         f_reg, f_next;
    logic [30:0]         hp_reg, hp_next;
    logic [29:0]         v_reg, v_next;
    logic [3:0]          k_reg, k_next;
    logic [21:0]         term_reg, term_next;
    logic [3:0]          lab_reg, lab_next;
    logic [3:0]          c_reg, c_next;
    logic [1:0]          err_reg, err_next;
    logic [3:0]          m_label_reg, m_label_next;
    logic [31:0]         m_score_reg, m_score_next;
    logic [1:0]          m_status_reg, m_status_next;
    logic                m_last_reg, m_last_next;

    logic signed [15:0]  qvec_reg [MAX_FEATURES];
    logic [31:0]         scores_reg [MAX_CLASSES];

    // request fields
    logic [1:0]          req;
    logic [15:0]         fval;
    logic [3:0]          fclass;
    logic                s_acc;
    logic [4:0]          fc_eff;
    logic                row_done;
    logic                m_free;

    // memories and multiplier
    logic                feat_we, lab_we;
    logic [FADDR_W-1:0]  feat_waddr, feat_raddr;
    logic [15:0]         feat_rdata;
    logic [3:0]          lab_rdata;
    logic [31:0]         mul_a, mul_b;
    logic [63:0]         prod;

    // working values
    logic                qv_we;
    logic                sc_we, sc_clr;
    logic [3:0]          sc_addr;
    logic [31:0]         sc_rd;
    logic [31:0]         sc_wdata;
    logic [32:0]         sc_sum;
    logic signed [16:0]  diff;
    logic [16:0]         diff_abs;
    logic [60:0]         x_full;
    logic [24:0]         x20;
    logic [29:0]         q0, q1;
    logic [33:0]         rem;

    assign req    = s_tuser;
    assign fval   = s_tdata[15:0];
    assign fclass = s_tdata[19:16];

    assign s_tready = (state_reg == S_IDLE);
    assign s_acc    = s_tvalid && s_tready;
    assign m_free   = !m_valid_reg || m_tready;

    // register zero reads as one feature, anything above the maximum as the maximum
    assign fc_eff   = (fcnt_reg == 5'd0) ? 5'd1 : ((fcnt_reg > FEAT_TOP) ? FEAT_TOP : fcnt_reg);
    assign row_done = ({1'b0, elem_reg} + 5'd1) >= fc_eff;

    // training store writes happen on the accepting edge
    assign feat_we    = s_acc && (req == REQ_LOAD) && (rows_reg != ROWS_FULL);
    assign lab_we     = feat_we && row_done;
    assign feat_waddr = {rows_reg[ROW_AW-1:0], elem_reg};
    assign feat_raddr = {row_reg[ROW_AW-1:0], j_reg};
    assign qv_we      = s_acc && (req == REQ_QUERY);

    kpc_ram #(.WIDTH(16), .DEPTH(MAX_ROWS * MAX_FEATURES)) u_feat_ram (
        .aclk  (aclk),
        .we    (feat_we),
        .waddr (feat_waddr),
        .wdata (fval),
        .raddr (feat_raddr),
        .rdata (feat_rdata)
    );

    kpc_ram #(.WIDTH(4), .DEPTH(MAX_ROWS)) u_lab_ram (
        .aclk  (aclk),
        .we    (lab_we),
        .waddr (rows_reg[ROW_AW-1:0]),
        .wdata (clamp_label(fclass)),
        .raddr (row_reg[ROW_AW-1:0]),
        .rdata (lab_rdata)
    );

    kpc_mul u_mul (
        .aclk (aclk),
        .a    (mul_a),
        .b    (mul_b),
        .prod (prod)
    );

    // one score read port, shared by accumulation and result scan
    assign sc_addr  = (state_reg == S_OUT) ? c_reg : lab_reg;
    assign sc_rd    = scores_reg[sc_addr];
    assign sc_sum   = {1'b0, sc_rd} + {11'd0, term_reg};
    assign sc_wdata = sc_sum[32] ? 32'hFFFF_FFFF : sc_sum[31:0];

    // feature difference and its magnitude
    assign diff     = 17'(qvec_reg[j_reg]) - 17'(signed'(feat_rdata));
    assign diff_abs = diff[16] ? 17'(-diff) : 17'(diff);

    // d*d*k assembled from two partial products, then the q.20 window
    assign x_full = {prod[28:0], 32'd0} + {6'd0, xlo_reg};
    assign x20    = x_full[60:36];

    // division by k through its reciprocal, one correction step
    assign q0  = prod[61:32];
    assign rem = {4'd0, v_reg} - (34'(q0) * 34'(k_reg));
    assign q1  = (rem >= 34'(k_reg)) ? (q0 + 30'd1) : q0;

    always_comb begin
        state_next    = state_reg;
        fcnt_next     = fcnt_reg;
        elem_next     = elem_reg;
        rows_next     = rows_reg;
        mask_next     = mask_reg;
        m_valid_next  = m_valid_reg;
        row_next      = row_reg;
        j_next        = j_reg;
        d_next        = d_reg;
        dhi_next      = dhi_reg;
        xlo_next      = xlo_reg;
        a_next        = a_reg;
        cnt_next      = cnt_reg;
        f_next        = f_reg;
        hp_next       = hp_reg;
        v_next        = v_reg;
        k_next        = k_reg;
        term_next     = term_reg;
        lab_next      = lab_reg;
        c_next        = c_reg;
        err_next      = err_reg;
        m_label_next  = m_label_reg;
        m_score_next  = m_score_reg;
        m_status_next = m_status_reg;
        m_last_next   = m_last_reg;
        mul_a         = 32'd0;
        mul_b         = 32'd0;
        sc_we         = 1'b0;
        sc_clr        = 1'b0;

        if (cfg_we) begin
            fcnt_next = cfg_wdata;
        end

        // result taken
        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE: begin
                if (s_acc) begin
                    case (req)
                        REQ_CLEAR: begin
                            rows_next = '0;
                            mask_next = '0;
                            elem_next = '0;
                        end
                        REQ_LOAD: begin
                            if (rows_reg == ROWS_FULL) begin
                                err_next   = ST_FULL;
                                state_next = S_EMIT;
                            end else if (row_done) begin
                                elem_next = '0;
                                rows_next = rows_reg + ROW_CW'(1);
                                mask_next = mask_reg | (16'd1 << clamp_label(fclass));
                            end else begin
                                elem_next = elem_reg + 4'd1;
                            end
                        end
                        REQ_QUERY: begin
                            if (row_done) begin
                                elem_next = '0;
                                if (rows_reg == '0) begin
                                    err_next   = ST_NO_TRAIN;
                                    state_next = S_EMIT;
                                end else begin
                                    sc_clr     = 1'b1;
                                    row_next   = '0;
                                    j_next     = '0;
                                    d_next     = '0;
                                    state_next = S_RD;
                                end
                            end else begin
                                elem_next = elem_reg + 4'd1;
                            end
                        end
                        default: begin
                            // unknown request, dropped
                        end
                    endcase
                end
            end
            S_EMIT: begin
                if (m_free) begin
                    m_valid_next  = 1'b1;
                    m_label_next  = '0;
                    m_score_next  = '0;
                    m_status_next = err_reg;
                    m_last_next   = 1'b1;
                    state_next    = S_IDLE;
                end
            end
            S_RD: begin
                state_next = S_DIFF;
            end
            S_DIFF: begin
                lab_next   = lab_rdata;
                mul_a      = {16'd0, diff_abs[15:0]};
                mul_b      = {16'd0, diff_abs[15:0]};
                state_next = S_ACC;
            end
            S_ACC: begin
                d_next = d_reg + {4'd0, prod[31:0]};
                if (({1'b0, j_reg} + 5'd1) >= fc_eff) begin
                    state_next = S_K0;
                end else begin
                    j_next     = j_reg + 4'd1;
                    state_next = S_RD;
                end
            end
            S_K0: begin
                if (d_reg > D_LIMIT) begin
                    term_next  = '0;
                    state_next = S_ADD;
                end else begin
                    mul_a      = {13'd0, d_reg[18:0]};
                    mul_b      = {13'd0, d_reg[18:0]};
                    state_next = S_K1;
                end
            end
            S_K1: begin
                dhi_next   = prod[37:32];
                mul_a      = prod[31:0];
                mul_b      = K_Q24;
                state_next = S_K2;
            end
            S_K2: begin
                xlo_next   = prod[54:0];
                mul_a      = {26'd0, dhi_reg};
                mul_b      = K_Q24;
                state_next = S_K3;
            end
            S_K3: begin
                if (x20 > X_LIMIT) begin
                    term_next  = '0;
                    state_next = S_ADD;
                end else begin
                    cnt_next   = x20[24:20];
                    f_next     = {x20[19:0], 10'd0};
                    a_next     = Q30_E;
                    state_next = S_EXP;
                end
            end
            S_EXP: begin
                // e times e^-1 once for each unit of the integer part
                if (cnt_reg == 5'd0) begin
                    hp_next    = Q30_ONE;
                    k_next     = 4'd10;
                    state_next = S_H0;
                end else begin
                    mul_a      = a_reg;
                    mul_b      = Q30_EINV;
                    state_next = S_EXPW;
                end
            end
            S_EXPW: begin
                a_next     = prod[61:30];
                cnt_next   = cnt_reg - 5'd1;
                state_next = S_EXP;
            end
            S_H0: begin
                mul_a      = {2'd0, f_reg};
                mul_b      = {1'b0, hp_reg};
                state_next = S_H1;
            end
            S_H1: begin
                v_next = prod[59:30];
                if (k_reg == 4'd1) begin
                    hp_next    = Q30_ONE - {1'b0, prod[59:30]};
                    state_next = S_FIN;
                end else begin
                    mul_a      = {2'd0, prod[59:30]};
                    mul_b      = recip(k_reg);
                    state_next = S_H2;
                end
            end
            S_H2: begin
                hp_next    = Q30_ONE - {1'b0, q1};
                k_next     = k_reg - 4'd1;
                state_next = S_H0;
            end
            S_FIN: begin
                mul_a      = a_reg;
                mul_b      = {1'b0, hp_reg};
                state_next = S_TERM;
            end
            S_TERM: begin
                term_next  = prod[61:40];
                state_next = S_ADD;
            end
            S_ADD: begin
                sc_we    = 1'b1;
                row_next = row_reg + ROW_CW'(1);
                if ((row_reg + ROW_CW'(1)) == rows_reg) begin
                    c_next     = '0;
                    state_next = S_OUT;
                end else begin
                    j_next     = '0;
                    d_next     = '0;
                    state_next = S_RD;
                end
            end
            S_OUT: begin
                // scan labels upward, one per cycle unless stalled, emitting the present ones
                if (mask_reg[c_reg]) begin
                    if (m_free) begin
                        m_valid_next  = 1'b1;
                        m_label_next  = c_reg;
                        m_score_next  = sc_rd;
                        m_status_next = ST_OK;
                        m_last_next   = ((mask_reg >> c_reg) == 16'd1);
                        if ((mask_reg >> c_reg) == 16'd1) begin
                            state_next = S_IDLE;
                        end else begin
                            c_next = c_reg + 4'd1;
                        end
                    end
                end else if (c_reg == 4'd15) begin
                    state_next = S_IDLE;
                end else begin
                    c_next = c_reg + 4'd1;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            fcnt_reg    <= 5'd1;
            elem_reg    <= '0;
            rows_reg    <= '0;
            mask_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            fcnt_reg    <= fcnt_next;
            elem_reg    <= elem_next;
            rows_reg    <= rows_next;
            mask_reg    <= mask_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        row_reg      <= row_next;
        j_reg        <= j_next;
        d_reg        <= d_next;
        dhi_reg      <= dhi_next;
        xlo_reg      <= xlo_next;
        a_reg        <= a_next;
        cnt_reg      <= cnt_next;
        f_reg        <= f_next;
        hp_reg       <= hp_next;
        v_reg        <= v_next;
        k_reg        <= k_next;
        term_reg     <= term_next;
        lab_reg      <= lab_next;
        c_reg        <= c_next;
        err_reg      <= err_next;
        m_label_reg  <= m_label_next;
        m_score_reg  <= m_score_next;
        m_status_reg <= m_status_next;
        m_last_reg   <= m_last_next;
        if (qv_we) begin
            qvec_reg[elem_reg] <= signed'(fval);
        end
        if (sc_clr) begin
            for (int i = 0; i < MAX_CLASSES; i++) begin
                scores_reg[i] <= '0;
            end
        end else if (sc_we) begin
            scores_reg[lab_reg] <= sc_wdata;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {4'd0, m_score_reg, m_label_reg};
    assign m_tuser  = m_status_reg;
    assign m_tlast  = m_last_reg;

endmodule

/* rtl/core/kpc_checker.sv */
// port level checks of the kernel proximity classifier and their bind
module kpc_port_checks (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [39:0] m_tdata,
    input logic [1:0]  m_tuser,
    input logic        m_tlast
);
    import kpc_pkg::*;

    // no result right after reset
    a_reset_quiet: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    // a stalled result holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
            && $stable(m_tlast))
        else $error("stalled result changed");

    // error results are single, empty and last
    a_err_shape: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser != ST_OK) |-> m_tlast && (m_tdata == 40'd0))
        else $error("malformed error result");

    // a result in the scan leaves no request accepted in that cycle
    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser == ST_OK) && !m_tlast |-> !s_tready)
        else $error("request taken during result scan");

endmodule

bind kernel_proximity_classifier kpc_port_checks u_kpc_port_checks (.*);

/* tb/kpc_checker.sv */
// result checker of the kernel proximity classifier: predicts every result and compares it
`timescale 1ns / 100ps
module kpc_checker
    import kpc_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [4:0]  cfg_wdata,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [23:0] s_tdata,
    input  logic [1:0]  s_tuser,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [39:0] m_tdata,
    input  logic [1:0]  m_tuser,
    input  logic        m_tlast,
    output int          mismatches,
    output int          pending
);

    typedef struct packed {
        logic [3:0]  label;
        logic [31:0] score;
        logic [1:0]  status;
        logic        last;
    } class_result_t;

    class_result_t score_queue[$];

    logic [15:0] train_feat [MAX_ROWS][MAX_FEATURES];
    logic [3:0]  train_label [MAX_ROWS];
    logic [15:0] query_row [MAX_FEATURES];
    int          row_count;
    logic [15:0] present_mask;
    int          feat_idx;
    logic [4:0]  count_reg;

    assign pending = score_queue.size();

    function automatic longint unsigned kernel_weight(input longint unsigned d16);
        longint unsigned x20, n, f30, a, p;
        int k;
        if (d16 > (64'd7 << 16)) return 0;
        x20 = (d16 * d16 * 64'(K_Q24)) >> 36;
        if (x20 > (64'd16 << 20)) return 0;
        n   = x20 >> 20;
        f30 = (x20 & 64'hFFFFF) << 10;
        a   = 64'(Q30_E);
        for (k = 0; k < n; k++) a = (a * 64'(Q30_EINV)) >> 30;
        p = 64'(Q30_ONE);
        for (k = 10; k >= 1; k--) p = 64'(Q30_ONE) - (((f30 * p) >> 30) / k);
        return (a * p) >> 40;
    endfunction

    function automatic int active_count();
        if (count_reg == 0) return 1;
        if (count_reg > MAX_FEATURES) return MAX_FEATURES;
        return count_reg;
    endfunction

    task automatic score_query();
        longint unsigned acc [16];
        longint unsigned d, s;
        longint signed diff;
        int total, n, fc;
        class_result_t r;
        fc = active_count();
        if (row_count == 0) begin
            r = '{4'd0, 32'd0, ST_NO_TRAIN, 1'b1};
            score_queue.push_back(r);
            return;
        end
        foreach (acc[c]) acc[c] = 0;
        for (int i = 0; i < row_count; i++) begin
            d = 0;
            for (int j = 0; j < fc; j++) begin
                diff = longint'($signed(query_row[j])) - longint'($signed(train_feat[i][j]));
                d += longint'(diff * diff);
            end
            s = acc[train_label[i]] + kernel_weight(d);
            acc[train_label[i]] = (s > 64'hFFFFFFFF) ? 64'hFFFFFFFF : s;
        end
        total = $countones(present_mask);
        n = 0;
        for (int c = 0; c < 16; c++) begin
            if (present_mask[c]) begin
                n++;
                r = '{4'(c), acc[c][31:0], ST_OK, n == total};
                score_queue.push_back(r);
            end
        end
    endtask

    task automatic take_request(input logic [1:0] req, input logic [15:0] val,
                                input logic [3:0] cls);
        class_result_t r;
        case (req)
            REQ_CLEAR: begin
                row_count    = 0;
                present_mask = '0;
                feat_idx     = 0;
            end
            REQ_LOAD, REQ_QUERY: begin
                if (req == REQ_LOAD && row_count >= MAX_ROWS) begin
                    r = '{4'd0, 32'd0, ST_FULL, 1'b1};
                    score_queue.push_back(r);
                    return;
                end
                if (req == REQ_LOAD) train_feat[row_count][feat_idx] = val;
                else query_row[feat_idx] = val;
                if (feat_idx + 1 < active_count()) begin
                    feat_idx = (feat_idx + 1) & 15;
                end else begin
                    feat_idx = 0;
                    if (req == REQ_LOAD) begin
                        // all sixteen labels fit below the class limit
                        train_label[row_count] = cls;
                        present_mask[cls] = 1'b1;
                        row_count++;
                    end else begin
                        score_query();
                    end
                end
            end
            default: ;
        endcase
    endtask

    always @(posedge aclk) begin
        class_result_t got, want;
        if (!aresetn) begin
            row_count    = 0;
            present_mask = '0;
            feat_idx     = 0;
            count_reg    = 5'd1;
        end else begin
            if (cfg_we) count_reg = cfg_wdata;
            if (s_tvalid && s_tready) take_request(s_tuser, s_tdata[15:0], s_tdata[19:16]);
            if (m_tvalid && m_tready) begin
                got = '{m_tdata[3:0], m_tdata[35:4], m_tuser, m_tlast};
                if (score_queue.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result: label %0d score %h status %0d last %0b",
                                 got.label, got.score, got.status, got.last);
                end else begin
                    want = score_queue.pop_front();
                    if (got !== want) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch: expected label %0d score %h status %0d last %0b, got label %0d score %h status %0d last %0b",
                                     want.label, want.score, want.status, want.last,
                                     got.label, got.score, got.status, got.last);
                    end
                end
            end
        end
    end

    initial mismatches = 0;

endmodule

/* tb/tb_top.sv */
// testbench top of the kernel proximity classifier: stimulus, reset and verdict
`timescale 1ns / 100ps
module tb_top;
    import kpc_pkg::*;

    localparam logic [1:0] REQ_IGNORED = 2'd3;   // undefined request kind, dropped by the block
    localparam int CYCLE_LIMIT = 2000000;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_we = 1'b0;
    logic [4:0]  cfg_wdata = '0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [23:0] s_tdata = '0;
    logic [1:0]  s_tuser = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [39:0] m_tdata;
    logic [1:0]  m_tuser;
    logic        m_tlast;
    int          mismatches;
    int          pending;

    int          feat_count;       // effective features per row
    logic [15:0] center;           // cluster center of the current phase
    bit          no_gaps;          // stretch with no idling on either side
    int          ready_stall;
    int          cycles;

    kernel_proximity_classifier DUT (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .m_tlast(m_tlast)
    );

    kpc_checker u_checker (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .m_tlast(m_tlast),
        .mismatches(mismatches), .pending(pending)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // result side: a random stall after every accepted result, none when no_gaps is set
    always @(posedge aclk) begin
        int w;
        if (m_tvalid && m_tready) begin
            w = no_gaps ? 0 : $urandom_range(0, 4);
            ready_stall <= w;
            m_tready    <= (w == 0);
        end else if (ready_stall != 0) begin
            ready_stall <= ready_stall - 1;
            m_tready    <= (ready_stall == 1);
        end else begin
            m_tready <= 1'b1;
        end
    end

    // watchdog
    always @(posedge aclk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // one request: optional idle gap, then hold valid until accepted
    task automatic send(input logic [1:0] req, input logic [15:0] val, input logic [3:0] cls);
        int gap;
        gap = no_gaps ? 0 : $urandom_range(0, 4);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {4'b0, cls, val};
        s_tuser  <= req;
        do @(posedge aclk); while (!s_tready);
    endtask

    // feature near the phase center, now and then anywhere in range
    function automatic logic [15:0] near_value();
        if ($urandom_range(0, 9) == 0) return 16'($urandom);
        return center + 16'($urandom_range(0, 400)) - 16'd200;
    endfunction

    task automatic load_row(input logic [3:0] label);
        for (int i = 0; i < feat_count; i++)
            send(REQ_LOAD, near_value(), (i == feat_count - 1) ? label : 4'($urandom));
    endtask

    task automatic query_row();
        for (int i = 0; i < feat_count; i++)
            send(REQ_QUERY, near_value(), 4'($urandom));
    endtask

    // wait out every result, then the block's own busy time, then new count and a clear
    task automatic new_phase(input logic [4:0] count);
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (pending != 0);
        repeat (40) @(posedge aclk);
        cfg_we    <= 1'b1;
        cfg_wdata <= count;
        @(posedge aclk);
        cfg_we     <= 1'b0;
        feat_count = (count == 0) ? 1 : (count > MAX_FEATURES) ? MAX_FEATURES : count;
        center     = 16'($urandom_range(0, 2000)) - 16'd1000;
        no_gaps    = ($urandom_range(0, 3) == 0);
        send(REQ_CLEAR, 16'($urandom), 4'($urandom));
    endtask

    initial begin
        logic [4:0] counts [8] = '{5'd0, 5'd31, 5'd2, 5'd3, 5'd5, 5'd8, 5'd4, 5'd1};
        logic [15:0] edge_vals [16] = '{16'h8000, 16'h7FFF, 16'h0000, 16'hFFFF, 16'h0001,
                                        16'h5555, 16'hAAAA, 16'h0100, 16'hFF00, 16'h00FF,
                                        16'h1234, 16'hEDCB, 16'h0F0F, 16'hF0F0, 16'h3C3C,
                                        16'hC3C3};
        int ops;
        cycles      = 0;
        ready_stall = 0;
        no_gaps     = 1'b0;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // full-width query on an empty store, which also fills every query entry
        new_phase(5'd16);
        foreach (edge_vals[i]) send(REQ_QUERY, edge_vals[i], 4'(i));
        send(REQ_IGNORED, 16'hFFFF, 4'hF);

        // small rows: two classes, a query, a row shared by loads and queries
        new_phase(5'd2);
        send(REQ_LOAD, 16'h0000, 4'd3);
        send(REQ_LOAD, 16'h0080, 4'd15);
        send(REQ_LOAD, 16'h7FFF, 4'd0);
        send(REQ_LOAD, 16'h8000, 4'd0);
        send(REQ_QUERY, 16'h0010, 4'd0);
        send(REQ_QUERY, 16'h0070, 4'd0);
        send(REQ_LOAD, 16'h0000, 4'd7);
        send(REQ_QUERY, 16'h0000, 4'd7);     // completes the row as a query
        send(REQ_LOAD, 16'h0040, 4'd9);
        send(REQ_CLEAR, 16'h0000, 4'd0);     // drops the partial row
        send(REQ_QUERY, 16'h0000, 4'd0);
        send(REQ_QUERY, 16'h0000, 4'd0);

        // random phases over several row widths
        foreach (counts[p]) begin
            new_phase(counts[p]);
            repeat ($urandom_range(1, 2)) load_row(4'($urandom_range(0, 15)));
            ops = (feat_count > 4) ? 1 : 2;
            repeat (ops) begin
                case ($urandom_range(0, 9))
                    0, 1:    load_row(4'($urandom));
                    2:       send(REQ_IGNORED, 16'($urandom), 4'($urandom));
                    3: begin
                        // partial load row finished by query items
                        send(REQ_LOAD, near_value(), 4'($urandom));
                        for (int i = 1; i < feat_count; i++)
                            send(REQ_QUERY, near_value(), 4'($urandom));
                        if (feat_count == 1) query_row();
                    end
                    4: begin
                        send(REQ_QUERY, near_value(), 4'($urandom));
                        send(REQ_CLEAR, 16'($urandom), 4'($urandom));
                        load_row(4'($urandom));
                    end
                    default: query_row();
                endcase
            end
            query_row();
        end

        // single features: fill the store, then loads into a full store
        new_phase(5'd1);
        repeat (MAX_ROWS) send(REQ_LOAD, near_value(), 4'($urandom));
        send(REQ_LOAD, near_value(), 4'($urandom));
        send(REQ_LOAD, near_value(), 4'($urandom));
        query_row();
        send(REQ_LOAD, near_value(), 4'($urandom));
        query_row();

        s_tvalid <= 1'b0;
        do @(posedge aclk); while (pending != 0);
        repeat (100) @(posedge aclk);
        if (mismatches == 0 && pending == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
